// ===== sv/cllct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cllct_pkg
// Types and constants shared by the channel load link cost table.
// ----------------------------------------------------------------------------
package cllct_pkg;

    localparam int unsigned CfgW = 23;

    typedef enum logic [1:0] {
        K_CLEAR = 2'd0,
        K_HELLO = 2'd1,
        K_TICK  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  link;
        logic        foreign_present;
        logic [7:0]  foreign_lq;
        logic [31:0] meas_time;
        logic [31:0] busy_time;
        logic [31:0] nav_reads;
        logic [31:0] nav_busy;
    } t_in_item;

    typedef struct packed {
        logic [3:0] out_link;
        logic [8:0] cost;
        logic [7:0] lq_value;
        logic [7:0] nlq_value;
        logic [7:0] load_value;
        logic       is_summary;
        logic       changed_any;
        logic       last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_HELLO_RD,
        S_HELLO_WR,
        S_DIV,
        S_AVG_RD,
        S_AVG_WR,
        S_HYS_RD,
        S_HYS_WR,
        S_CU_RD,
        S_CU_WR,
        S_SUM
    } t_state;

    // true when smoothed and current differ by more than 10 percent, or current rises to 255
    function automatic logic differs_enough(input logic [7:0] sm, input logic [7:0] now);
        logic [7:0] tenth;
        tenth = 8'((16'(sm) * 16'd205) >> 11);
        if (sm < now) begin
            differs_enough = (now == 8'd255) || ((now - sm) > tenth);
        end else if (sm > now) begin
            differs_enough = (sm - now) > tenth;
        end else begin
            differs_enough = 1'b0;
        end
    endfunction

endpackage

// ===== sv/channel_load_link_cost_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_load_link_cost_table
// Per-link quality table with channel load averaging and cost hysteresis.
// ----------------------------------------------------------------------------
// Channels: i_in_* carries clear, hello and tick items; o_out_* carries the
// result items of a tick (one per copied link, then a summary with last=1);
// i_cfg_* writes the broken cost ceiling, only while the block is idle.
// Clear and hello give no result. A tick runs two 40-step restoring
// divisions (one bit per cycle, shared unit), then an averaging pass, a
// hysteresis pass and, if any link was copied, a catch-up pass over NUM_LINKS
// entries, each entry a read state and a write state of the link memory; the
// hysteresis and catch-up write states wait while the output stalls.
// Link qualities live in one synchronous memory of NUM_LINKS words with a
// registered read port; active flags are flip-flops cleared by reset, and an
// inactive entry's word is never used, so the memory needs no clearing pass.
// Reset (synchronous, active low) empties the table and sets the ceiling to
// 4194304. When the receiver stalls, the sequencer waits with the result in
// the output register and takes no new item until the tick has finished.
// ----------------------------------------------------------------------------
module channel_load_link_cost_table
    import cllct_pkg::*;
#(
    parameter int NUM_LINKS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CfgW-1:0]      i_cfg_data
);

    localparam int IW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
    localparam int CW = $clog2(NUM_LINKS + 1);

    // memory word: lq_now, nlq_now, lq_smooth, nlq_smooth
    logic [31:0] mem [NUM_LINKS];
    logic [31:0] r_rd;
    logic [IW-1:0] mem_addr;
    logic          mem_we;
    logic [31:0]   mem_wd;

    t_state r_state, n_state;
    t_in_item r_item;
    logic [CfgW-1:0] r_broken;
    logic [NUM_LINKS-1:0] r_active, r_copied;
    logic [7:0] r_load, n_load;
    logic [CW-1:0] r_idx;
    logic r_trig;
    logic r_ov, n_ov;
    t_out_item r_out, n_out;

    // divider
    logic [39:0] r_rem;
    logic [31:0] r_den;
    logic [39:0] r_quo;
    logic [5:0]  r_cnt;
    logic        r_second;
    logic [7:0]  r_m;
    logic [40:0] trial;
    logic [7:0]  sat_q;

    logic [7:0] lq_now, nlq_now, lq_sm, nlq_sm;
    logic       idx_act, idx_end, hys_hit, cu_hit;
    logic [9:0] sum;
    logic [CfgW-1:0] clamp;
    logic [8:0] cost_v;
    logic [IW-1:0] idx_a;
    logic [IW-1:0] link_i;
    logic link_ok;

    assign idx_a   = r_idx[IW-1:0];
    assign idx_end = (r_idx == CW'(NUM_LINKS));
    assign idx_act = !idx_end && r_active[idx_a];
    assign link_ok = (32'(r_item.link) < 32'(NUM_LINKS));
    assign link_i  = IW'(r_item.link);

    assign {lq_now, nlq_now, lq_sm, nlq_sm} = r_rd;
    assign hys_hit = differs_enough(lq_sm, lq_now) || differs_enough(nlq_sm, nlq_now);
    assign cu_hit  = !(lq_sm == 8'd255 && nlq_sm == 8'd255) &&
                     !(lq_sm == lq_now && nlq_sm == nlq_now) && !r_copied[idx_a];

    assign sum    = 10'(lq_now) + 10'(nlq_now);
    assign clamp  = (CfgW'(sum) > r_broken) ? r_broken : CfgW'(sum);
    assign cost_v = (clamp == '0) ? 9'd1 : clamp[8:0];

    assign trial = {r_rem[38:0], r_quo[39]} - {9'd0, r_den};
    assign sat_q = (r_den == '0) ? 8'd0 : ((r_quo[39:8] != '0) ? 8'd255 : r_quo[7:0]);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        r_rd <= mem[mem_addr];
    end

    always_comb begin
        mem_addr = idx_a;
        mem_we   = 1'b0;
        mem_wd   = r_rd;
        case (r_state)
            S_CLR: begin
                mem_addr = link_i;
                mem_we   = link_ok;
                mem_wd   = '0;
            end
            S_HELLO_RD: mem_addr = link_i;
            S_HELLO_WR: begin
                mem_addr = link_i;
                mem_we   = 1'b1;
                mem_wd   = {lq_now, (r_item.foreign_present ? r_item.foreign_lq : 8'd0),
                            lq_sm, nlq_sm};
            end
            S_AVG_WR: begin
                mem_we = idx_act;
                mem_wd = {n_load, nlq_now, lq_sm, nlq_sm};
            end
            S_HYS_WR: begin
                mem_we = idx_act && hys_hit && !(r_ov && !i_out_ready);
                mem_wd = {lq_now, nlq_now, lq_now, nlq_now};
            end
            S_CU_WR: begin
                mem_we = idx_act && cu_hit && !(r_ov && !i_out_ready);
                mem_wd = {lq_now, nlq_now, lq_now, nlq_now};
            end
            default: ;
        endcase
    end

    assign n_load = 8'((9'(r_load) + 9'(r_m)) >> 1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_kind'(i_in_data.kind))
                        K_CLEAR: n_state = S_CLR;
                        K_HELLO: n_state = S_HELLO_RD;
                        K_TICK:  n_state = S_DIV;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR:      n_state = S_IDLE;
            S_HELLO_RD: n_state = (link_ok && r_active[link_i]) ? S_HELLO_WR : S_IDLE;
            S_HELLO_WR: n_state = S_IDLE;
            S_DIV:      n_state = (r_cnt == 6'd40 && r_second) ? S_AVG_RD : S_DIV;
            S_AVG_RD:   n_state = idx_end ? S_HYS_RD : S_AVG_WR;
            S_AVG_WR:   n_state = S_AVG_RD;
            S_HYS_RD:   n_state = idx_end ? (r_trig ? S_CU_RD : S_SUM) : S_HYS_WR;
            S_HYS_WR: begin
                if (!(r_ov && !i_out_ready)) n_state = S_HYS_RD;
            end
            S_CU_RD:    n_state = idx_end ? S_SUM : S_CU_WR;
            S_CU_WR: begin
                if (!(r_ov && !i_out_ready)) n_state = S_CU_RD;
            end
            S_SUM: begin
                if (!(r_ov && !i_out_ready)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        n_ov  = r_ov && !i_out_ready;
        n_out = r_out;
        if (!(r_ov && !i_out_ready)) begin
            case (r_state)
                S_HYS_WR, S_CU_WR: begin
                    if (idx_act && ((r_state == S_HYS_WR) ? hys_hit : cu_hit)) begin
                        n_ov              = 1'b1;
                        n_out.out_link    = 4'(r_idx);
                        n_out.cost        = cost_v;
                        n_out.lq_value    = lq_now;
                        n_out.nlq_value   = nlq_now;
                        n_out.load_value  = r_load;
                        n_out.is_summary  = 1'b0;
                        n_out.changed_any = 1'b1;
                        n_out.last        = 1'b0;
                    end
                end
                S_SUM: begin
                    n_ov              = 1'b1;
                    n_out             = '0;
                    n_out.load_value  = r_load;
                    n_out.is_summary  = 1'b1;
                    n_out.changed_any = r_trig;
                    n_out.last        = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_broken <= CfgW'(4194304);
            r_active <= '0;
            r_load   <= '0;
            r_ov     <= 1'b0;
            r_trig   <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                r_broken <= i_cfg_data;
            end
            if (r_state == S_IDLE && i_in_valid) begin
                r_idx  <= '0;
                r_trig <= 1'b0;
            end
            if (r_state == S_CLR && link_ok) begin
                r_active[link_i] <= 1'b1;
            end
            if (r_state == S_AVG_WR) begin
                if (idx_act) r_load <= n_load;
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == S_AVG_RD && idx_end) r_idx <= '0;
            if (r_state == S_HYS_RD && idx_end) r_idx <= '0;
            if ((r_state == S_HYS_WR || r_state == S_CU_WR) && !(r_ov && !i_out_ready)) begin
                r_idx <= r_idx + 1'b1;
                if (r_state == S_HYS_WR && idx_act && hys_hit) r_trig <= 1'b1;
            end
        end
    end

    // payload and divider registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == S_IDLE && i_in_valid) begin
            r_item   <= i_in_data;
            r_copied <= '0;
            r_rem    <= '0;
            r_quo    <= {i_in_data.busy_time, 8'd0} - {8'd0, i_in_data.busy_time};
            r_den    <= i_in_data.meas_time;
            r_cnt    <= '0;
            r_second <= 1'b0;
            r_m      <= '0;
        end else if (r_state == S_DIV) begin
            if (r_cnt == 6'd40) begin
                r_m      <= (sat_q > r_m) ? sat_q : r_m;
                r_second <= 1'b1;
                r_rem    <= '0;
                r_quo    <= {r_item.nav_busy, 8'd0} - {8'd0, r_item.nav_busy};
                r_den    <= r_item.nav_reads;
                r_cnt    <= '0;
            end else begin
                if (!trial[40]) begin
                    r_rem <= trial[39:0];
                    r_quo <= {r_quo[38:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[38:0], r_quo[39]};
                    r_quo <= {r_quo[38:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (r_state == S_HYS_WR && idx_act && hys_hit && !(r_ov && !i_out_ready)) begin
            r_copied[idx_a] <= 1'b1;
        end
    end

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

    a_busy_no_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_in_ready) else $error("input taken while busy");

    a_sum_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.last |-> o_out_data.is_summary)
        else $error("last without summary");

    a_cost_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.is_summary |-> o_out_data.cost != 9'd0)
        else $error("zero link cost");

endmodule
